@@ rtl/utf8_byte_stream_decoder_assert.svh @@
// Assertion macros shared by the UTF-8 decoder RTL files.
// Included by u8d_decode.sv and u8d_result_fifo.sv; the bodies compile away under SYNTHESIS.
`ifndef UTF8_BYTE_STREAM_DECODER_ASSERT_SVH
`define UTF8_BYTE_STREAM_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside of reset.
`define U8D_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("u8d assertion failed");

// Condition that must never be true outside of reset.
`define U8D_NEVER(lbl, clk, rstn, cond) \
	`U8D_ASSERT(lbl, clk, rstn, !(cond))

`else

`define U8D_ASSERT(lbl, clk, rstn, prop)
`define U8D_NEVER(lbl, clk, rstn, cond)

`endif

`endif

@@ rtl/u8d_pkg.sv @@
// Shared types and constants of the UTF-8 byte stream decoder.
// No dependencies; imported by every RTL module of the block.
package u8d_pkg;

	// Widths of the result fields.
	localparam int CP_W   = 21;
	localparam int BYTE_W = 8;

	// Byte ranges and masks of the UTF-8 encoding.
	localparam logic [BYTE_W-1:0] ASCII_MAX   = 8'h7f;
	localparam logic [BYTE_W-1:0] LEAD2_MIN   = 8'hc0;
	localparam logic [BYTE_W-1:0] LEAD2_MAX   = 8'hdf;
	localparam logic [BYTE_W-1:0] LEAD3_MIN   = 8'he0;
	localparam logic [BYTE_W-1:0] LEAD3_MAX   = 8'hef;
	localparam logic [BYTE_W-1:0] LEAD4_MIN   = 8'hf0;
	localparam logic [BYTE_W-1:0] LEAD4_MAX   = 8'hf7;
	localparam logic [BYTE_W-1:0] LEAD23_MASK = 8'h1f;
	localparam logic [BYTE_W-1:0] LEAD4_MASK  = 8'h07;
	localparam logic [1:0]        CONT_TAG    = 2'b10;
	localparam logic [BYTE_W-1:0] NUL_BYTE    = 8'h00;

	// Replacement character '?' for malformed input.
	localparam logic [CP_W-1:0] QMARK = 21'h00003f;

	// Result queue geometry.
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// One decoded result.
	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            end_of_text;
	} result_t;

	// Results produced by one byte: zero, one or two of them.
	typedef struct packed {
		logic [1:0] num;
		result_t    first;
		result_t    second;
	} push_t;

endpackage

@@ rtl/u8d_decode.sv @@
// Sequence decoder: holds the multi-byte sequence state and turns one byte into results.
// Depends on u8d_pkg and utf8_byte_stream_decoder_assert.svh.
`include "utf8_byte_stream_decoder_assert.svh"

module u8d_decode (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic [u8d_pkg::BYTE_W-1:0]  byte_in,
	output u8d_pkg::push_t              push
);
	import u8d_pkg::*;

	logic [1:0]      left_q;
	logic [CP_W-1:0] part_q;
	logic            bad_q;

	logic [1:0]      next_left;
	logic [CP_W-1:0] next_part;
	logic            next_bad;
	logic            cont_bad;
	logic [CP_W-1:0] shifted;

	// Continuation byte check and payload accumulation.
	assign cont_bad = bad_q || (byte_in[7:6] != CONT_TAG);
	assign shifted  = {part_q[CP_W-7:0], byte_in[5:0]};

	// Decode of the current byte against the sequence state.
	always_comb begin
		push      = '0;
		next_left = left_q;
		next_part = part_q;
		next_bad  = bad_q;
		if (left_q == 2'd0) begin
			priority if (byte_in == NUL_BYTE) begin
				push.num   = 2'd1;
				push.first = '{code_point: '0, end_of_text: 1'b1};
				next_part  = '0;
				next_bad   = 1'b0;
			end else if (byte_in <= ASCII_MAX) begin
				push.num   = 2'd1;
				push.first = '{code_point: {{(CP_W-BYTE_W){1'b0}}, byte_in},
					end_of_text: 1'b0};
			end else if (byte_in >= LEAD2_MIN && byte_in <= LEAD2_MAX) begin
				next_left = 2'd1;
				next_part = {{(CP_W-BYTE_W){1'b0}}, byte_in & LEAD23_MASK};
				next_bad  = 1'b0;
			end else if (byte_in >= LEAD3_MIN && byte_in <= LEAD3_MAX) begin
				next_left = 2'd2;
				next_part = {{(CP_W-BYTE_W){1'b0}}, byte_in & LEAD23_MASK};
				next_bad  = 1'b0;
			end else if (byte_in >= LEAD4_MIN && byte_in <= LEAD4_MAX) begin
				next_left = 2'd3;
				next_part = {{(CP_W-BYTE_W){1'b0}}, byte_in & LEAD4_MASK};
				next_bad  = 1'b0;
			end else begin
				push.num   = 2'd1;
				push.first = '{code_point: QMARK, end_of_text: 1'b0};
			end
		end else if (byte_in == NUL_BYTE) begin
			// A NUL cuts the open sequence short.
			push.num    = 2'd2;
			push.first  = '{code_point: QMARK, end_of_text: 1'b0};
			push.second = '{code_point: '0, end_of_text: 1'b1};
			next_left   = 2'd0;
			next_part   = '0;
			next_bad    = 1'b0;
		end else begin
			next_left = left_q - 2'd1;
			next_bad  = cont_bad;
			if (!cont_bad) begin
				next_part = shifted;
			end
			if (left_q == 2'd1) begin
				push.num   = 2'd1;
				push.first = '{code_point: (cont_bad ? QMARK : shifted),
					end_of_text: 1'b0};
				next_part  = '0;
				next_bad   = 1'b0;
			end
		end
	end

	// Sequence state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 2'd0;
			part_q <= '0;
			bad_q  <= 1'b0;
		end else if (fire) begin
			left_q <= next_left;
			part_q <= next_part;
			bad_q  <= next_bad;
		end
	end

	// A terminating result always leaves the decoder at the start of a new text.
	`U8D_ASSERT(a_end_clears, clk, arst_n, (fire && push.num != 2'd0 && push.first.end_of_text) |=> (left_q == 2'd0 && bad_q == 1'b0))
	// Two results only come from a cut sequence: '?' then the end marker.
	`U8D_ASSERT(a_two_results, clk, arst_n, (push.num == 2'd2) |-> (push.first.code_point == QMARK && push.second.end_of_text))
	// A bad sequence mark exists only while a sequence is open.
	`U8D_NEVER(a_bad_idle, clk, arst_n, bad_q && left_q == 2'd0)

endmodule

@@ rtl/u8d_result_fifo.sv @@
// Result queue: takes up to two results per cycle and hands out one per transaction.
// Depends on u8d_pkg and utf8_byte_stream_decoder_assert.svh.
`include "utf8_byte_stream_decoder_assert.svh"

module u8d_result_fifo (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push_en,
	input  u8d_pkg::push_t            push,
	output logic                      room,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [u8d_pkg::CP_W-1:0]  code_point,
	output logic                      end_of_text
);
	import u8d_pkg::*;

	result_t            entries [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic [1:0]         push_num;
	logic               pop;

	assign push_num  = push_en ? push.num : 2'd0;
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;
	// Room for the worst case of two results from the next byte.
	assign room      = (count_q <= CNT_W'(FIFO_DEPTH - 2));

	assign code_point  = entries[rd_ptr_q].code_point;
	assign end_of_text = entries[rd_ptr_q].end_of_text;

	// Result storage.
	always_ff @(posedge clk) begin
		if (push_num != 2'd0) begin
			entries[wr_ptr_q] <= push.first;
		end
		if (push_num == 2'd2) begin
			entries[wr_ptr_q + PTR_W'(1)] <= push.second;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_num);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push_num) - CNT_W'(pop);
		end
	end

	// The queue never holds more than its depth.
	`U8D_NEVER(a_count_max, clk, arst_n, count_q > CNT_W'(FIFO_DEPTH))
	// Pushes only land in free space.
	`U8D_ASSERT(a_no_overflow, clk, arst_n, (push_num != 2'd0) |-> (count_q + CNT_W'(push_num) <= CNT_W'(FIFO_DEPTH)))
	// The fill count follows pushes and pops.
	`U8D_ASSERT(a_count_track, clk, arst_n, 1'b1 |=> (count_q == $past(count_q) + CNT_W'($past(push_num)) - CNT_W'($past(pop))))

endmodule

@@ rtl/utf8_byte_stream_decoder.sv @@
// UTF-8 byte stream decoder top level: input register, sequence decoder and result queue.
// Flow: an accepted byte waits in the input register and is decoded when it advances to the queue.
// Throughput: one byte per cycle while the result queue has room; a NUL inside a sequence yields
// two results, drained at one per cycle while out_stall is low, through the four-entry result
// queue, which stalls input when under two slots free.
// Reset: arst_n clears the sequence state and empties the input register and result queue.
// Depends on u8d_pkg, u8d_decode and u8d_result_fifo.

module utf8_byte_stream_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [u8d_pkg::BYTE_W-1:0]  in_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [u8d_pkg::CP_W-1:0]    code_point,
	output logic                        end_of_text
);
	import u8d_pkg::*;

	logic               valid_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic               room;
	logic               advance;
	logic               in_take;
	push_t              push;

	assign advance  = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign in_take  = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= in_byte;
		end
	end

	u8d_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (advance),
		.byte_in (byte_s1),
		.push    (push)
	);

	u8d_result_fifo u_fifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.push_en     (advance),
		.push        (push),
		.room        (room),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.code_point  (code_point),
		.end_of_text (end_of_text)
	);

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of utf8_byte_stream_decoder: a scoreboard class predicts the decoded
// code points from every accepted byte, and plain tasks drive directed and random text with idle bursts.
// Depends on u8d_pkg and the decoder RTL.

import u8d_pkg::*;

// Predicts decoder results from accepted bytes and checks them in order.
class code_point_scoreboard;
	result_t                expected_points[$];
	logic [1:0]             seq_left;
	logic [CP_W-1:0]        seq_bits;
	logic                   seq_broken;
	int unsigned            errors;
	int unsigned            bytes_seen;
	int unsigned            points_seen;
	int unsigned            ends_seen;

	function new();
		seq_left    = 2'd0;
		seq_bits    = '0;
		seq_broken  = 1'b0;
		errors      = 0;
		bytes_seen  = 0;
		points_seen = 0;
		ends_seen   = 0;
	endfunction

	// Prints one line per mismatch and counts it.
	task report(string msg);
		errors++;
		$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	function void push_point(logic [CP_W-1:0] cp, logic eot);
		result_t r;
		r.code_point  = cp;
		r.end_of_text = eot;
		expected_points.push_back(r);
	endfunction

	function void clear_seq();
		seq_left   = 2'd0;
		seq_bits   = '0;
		seq_broken = 1'b0;
	endfunction

	function void open_seq(logic [1:0] left, logic [BYTE_W-1:0] bits);
		seq_left   = left;
		seq_bits   = {13'd0, bits};
		seq_broken = 1'b0;
	endfunction

	// Advances the predicted decoder state by one accepted byte.
	function void note_byte(logic [BYTE_W-1:0] b);
		bytes_seen++;
		if (seq_left == 2'd0) begin
			if (b == NUL_BYTE) begin
				push_point('0, 1'b1);
				clear_seq();
			end else if (b <= ASCII_MAX) begin
				push_point({13'd0, b}, 1'b0);
			end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
				open_seq(2'd1, b & LEAD23_MASK);
			end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
				open_seq(2'd2, b & LEAD23_MASK);
			end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
				open_seq(2'd3, b & LEAD4_MASK);
			end else begin
				push_point(QMARK, 1'b0);
			end
		end else if (b == NUL_BYTE) begin
			// A NUL cuts the open sequence short: a replacement, then the end of text.
			push_point(QMARK, 1'b0);
			push_point('0, 1'b1);
			clear_seq();
		end else begin
			// Once a sequence is broken, the remaining bytes are only counted off.
			if (seq_broken || b[7:6] != CONT_TAG)
				seq_broken = 1'b1;
			else
				seq_bits = {seq_bits[CP_W-7:0], b[5:0]};
			seq_left = seq_left - 2'd1;
			if (seq_left == 2'd0) begin
				push_point(seq_broken ? QMARK : seq_bits, 1'b0);
				clear_seq();
			end
		end
	endfunction

	// Compares one accepted result with the oldest expected one.
	task check_result(logic [CP_W-1:0] cp, logic eot);
		result_t want;
		points_seen++;
		if (eot === 1'b1)
			ends_seen++;
		if (expected_points.size() == 0) begin
			report($sformatf("result %h end %b with nothing expected", cp, eot));
			return;
		end
		want = expected_points.pop_front();
		if (cp !== want.code_point)
			report($sformatf("code_point %h, expected %h", cp, want.code_point));
		if (eot !== want.end_of_text)
			report($sformatf("end_of_text %b, expected %b", eot, want.end_of_text));
	endtask

	task check_drained();
		if (expected_points.size() != 0)
			report($sformatf("%0d results never arrived", expected_points.size()));
	endtask
endclass

module tb;
	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [BYTE_W-1:0]   in_byte;
	logic                out_valid;
	logic                out_stall;
	logic [CP_W-1:0]     code_point;
	logic                end_of_text;

	code_point_scoreboard sb;
	bit                   calm;
	int unsigned          gap_pct;
	int unsigned          stall_pct;
	int unsigned          sent_bytes;

	utf8_byte_stream_decoder i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.code_point  (code_point),
		.end_of_text (end_of_text)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Offers one byte, after an optional idle burst, and holds it until the block takes it.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		do @(posedge clk); while (in_stall);
		sent_bytes++;
	endtask

	function automatic logic [BYTE_W-1:0] random_lead(int len);
		case (len)
			2:       return BYTE_W'($urandom_range(LEAD2_MIN, LEAD2_MAX));
			3:       return BYTE_W'($urandom_range(LEAD3_MIN, LEAD3_MAX));
			default: return BYTE_W'($urandom_range(LEAD4_MIN, LEAD4_MAX));
		endcase
	endfunction

	// Sends one random piece of text: mostly well-formed characters, some noise and breakage.
	task automatic send_random_piece();
		int               kind;
		int               len;
		int               bad_at;
		logic [BYTE_W-1:0] b;
		kind = $urandom_range(0, 99);
		len  = $urandom_range(2, 4);
		if (kind < 35) begin
			send_byte(BYTE_W'($urandom_range(1, ASCII_MAX)));
		end else if (kind < 75) begin
			send_byte(random_lead(len));
			for (int k = 1; k < len; k++)
				send_byte(BYTE_W'($urandom_range(8'h80, 8'hbf)));
		end else if (kind < 83) begin
			send_byte(NUL_BYTE);
		end else if (kind < 90) begin
			send_byte(BYTE_W'($urandom_range(0, 255)));
		end else begin
			// One continuation byte goes wrong and the bytes after it are random; it may also be a NUL.
			bad_at = $urandom_range(1, len - 1);
			send_byte(random_lead(len));
			for (int k = 1; k < len; k++) begin
				if (k == bad_at) begin
					b = BYTE_W'($urandom_range(0, 255));
					if (b[7:6] == CONT_TAG)
						b[7] = 1'b0;
				end else if (k < bad_at) begin
					b = BYTE_W'($urandom_range(8'h80, 8'hbf));
				end else begin
					b = BYTE_W'($urandom_range(1, 255));
				end
				send_byte(b);
			end
		end
	endtask

	// Result side: random stall bursts, with quiet and busy phases.
	initial begin
		int unsigned phase_cycles;
		out_stall    <= 1'b0;
		stall_pct    = 10;
		phase_cycles = 0;
		forever begin
			@(posedge clk);
			phase_cycles++;
			if (phase_cycles % 256 == 0) begin
				case ($urandom_range(0, 2))
					0:       stall_pct = 0;
					1:       stall_pct = 10;
					default: stall_pct = 40;
				endcase
			end
			if (!calm && $urandom_range(0, 99) < stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Watches both channels; results are checked before the same edge's byte is noted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result(code_point, end_of_text);
			if (in_valid && !in_stall)
				sb.note_byte(in_byte);
		end
	end

	// Main sequence: reset, directed text, random text, drain and verdict.
	initial begin
		logic [BYTE_W-1:0] directed[$];
		int                pieces;
		int                wait_cycles;
		sb         = new();
		calm       = 1'b0;
		gap_pct    = 10;
		sent_bytes = 0;
		arst_n     = 1'b0;
		in_valid   <= 1'b0;
		in_byte    <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Field extremes, 2-byte sequences at both limits, a 3-byte one, the largest 4-byte one, broken and cut sequences.
		directed = {8'h00, 8'h7f, 8'h41, 8'h80, 8'hbf, 8'hf8, 8'hff,
			8'hc0, 8'h80, 8'hdf, 8'hbf, 8'he2, 8'h82, 8'hac,
			8'hf7, 8'hbf, 8'hbf, 8'hbf, 8'hc3, 8'h41,
			8'he2, 8'h41, 8'h80, 8'hf0, 8'h98, 8'h00};
		foreach (directed[k])
			send_byte(directed[k]);

		// Random text; the last stretch runs with no idling on either side.
		pieces = 0;
		while (sent_bytes < 900) begin
			if (pieces % 100 == 0) begin
				case ($urandom_range(0, 2))
					0:       gap_pct = 0;
					1:       gap_pct = 15;
					default: gap_pct = 50;
				endcase
			end
			if (sent_bytes >= 780)
				calm = 1'b1;
			send_random_piece();
			pieces++;
		end
		in_valid <= 1'b0;

		wait_cycles = 0;
		while (sb.expected_points.size() != 0 && wait_cycles < 1000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (16) @(posedge clk);
		sb.check_drained();

		$display("Decoded %0d bytes into %0d results, %0d of them text ends,",
			sb.bytes_seen, sb.points_seen, sb.ends_seen);
		$display("covering ASCII, 2- to 4-byte, malformed and NUL-cut sequences under idling.");
		if (sb.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Ends a hung run.
	initial begin
		#5000000;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
